// File: src/msq_pkg.sv
// Shared types and constants for the max_square_of_ones block.
// No dependencies; imported by every module of the block.
package msq_pkg;

    localparam int SIZE_W       = 11;
    localparam int POS_OUT_W    = 10;
    localparam int CFG_W        = 11;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT    = 11'd2047;
    localparam logic [CFG_W-1:0]  NUM_COLS_RST  = 11'd1024;

    // Per-beat control that travels down the pipe with each cell.
    typedef struct packed {
        logic vld;
        logic is_set;
        logic eof;
        logic wrap;
        logic first;
    } t_beat_ctl;

endpackage

// File: src/max_square_of_ones.sv
// Top level of the largest all-ones square finder.
// Instantiates msq_linebuf, msq_cell and msq_best; uses msq_pkg.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready   | i_cell_req, i_end_of_frame
//  result   | o_out_valid / i_out_ready | o_max_size, o_top_row, o_left_col
//  config   | i_cfg_wen                 | i_cfg_wdata (num_cols)
//
// One cell per cycle unless the input is stalled: accept issues the line-buffer read, the next
// stage forms the size and writes it back, the third tracks the maximum.
// A frame end passes the stage-1 and stage-2 controls before the tracker registers the result.
// Input stalls only while a finished result is untaken and another frame end
// reaches the tracker. Synchronous active-low reset; line buffer is not cleared.
module max_square_of_ones #(
    parameter int MAX_COLS = msq_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = msq_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [msq_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cell_req,
    input  logic                            i_end_of_frame,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [msq_pkg::SIZE_W-1:0]      o_max_size,
    output logic [msq_pkg::POS_OUT_W-1:0]   o_top_row,
    output logic [msq_pkg::POS_OUT_W-1:0]   o_left_col
);
    import msq_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int NW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CFG_W-1:0]  r_num_cols;
    logic [NW-1:0]     eff_cols;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic              accept;
    logic              adv;
    logic              hold;
    logic              wrap;
    t_beat_ctl         r_s1_ctl, n_s1_ctl;
    logic [CW-1:0]     r_s1_col;
    logic [RW-1:0]     r_s1_row;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] size;
    t_beat_ctl         s2_ctl;
    logic [SIZE_W-1:0] s2_size;
    logic [CW-1:0]     s2_col;
    logic [RW-1:0]     s2_row;

    assign adv        = !hold;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        priority if (r_num_cols == '0) begin
            eff_cols = NW'(1);
        end else if (NW'(r_num_cols) > NW'(MAX_COLS)) begin
            eff_cols = NW'(MAX_COLS);
        end else begin
            eff_cols = NW'(r_num_cols);
        end
    end

    assign wrap = (NW'(r_col) + NW'(1)) >= eff_cols;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            priority if (i_end_of_frame) begin
                n_col = '0;
                n_row = '0;
            end else if (wrap) begin
                n_col = '0;
                if (r_row != RW'(MAX_ROWS - 1)) begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_comb begin
        n_s1_ctl        = r_s1_ctl;
        n_s1_ctl.vld    = 1'b0;
        if (accept) begin
            n_s1_ctl.vld    = 1'b1;
            n_s1_ctl.is_set = i_cell_req;
            n_s1_ctl.eof    = i_end_of_frame;
            n_s1_ctl.wrap   = wrap;
            n_s1_ctl.first  = (r_row == '0) || (r_col == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NUM_COLS_RST;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_ctl   <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_num_cols <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_row <= n_row;
            if (adv) begin
                r_s1_ctl <= n_s1_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    // Same-entry overlap needs one column or a frame end at column 0; up is unused then.
    msq_linebuf #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_we    (r_s1_ctl.vld && adv),
        .i_waddr (r_s1_col),
        .i_wdata (size),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (up)
    );

    msq_cell #(
        .CW (CW),
        .RW (RW)
    ) u_cell (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_ctl     (r_s1_ctl),
        .i_col     (r_s1_col),
        .i_row     (r_s1_row),
        .i_up      (up),
        .o_size    (size),
        .o_ctl     (s2_ctl),
        .o_s2_size (s2_size),
        .o_s2_col  (s2_col),
        .o_s2_row  (s2_row)
    );

    msq_best #(
        .CW (CW),
        .RW (RW)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s2_ctl),
        .i_size      (s2_size),
        .i_col       (s2_col),
        .i_row       (s2_row),
        .i_out_ready (i_out_ready),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .o_max_size  (o_max_size),
        .o_top_row   (o_top_row),
        .o_left_col  (o_left_col)
    );

endmodule

// File: src/msq_linebuf.sv
// Line buffer holding the previous row's square sizes.
// One write port, one read port with registered data. Uses msq_pkg.
module msq_linebuf #(
    parameter int DEPTH = msq_pkg::DEF_MAX_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [msq_pkg::SIZE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [msq_pkg::SIZE_W-1:0] o_rdata
);
    import msq_pkg::*;

    logic [SIZE_W-1:0] r_mem [DEPTH];
    logic [SIZE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/msq_cell.sv
// Cell size: 0 if unset, 1 in row or column 0, else min of left, up, diagonal plus one.
// Holds the left/diagonal sizes and the stage register toward the tracker. Uses msq_pkg.
module msq_cell #(
    parameter int CW = 10,
    parameter int RW = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  msq_pkg::t_beat_ctl          i_ctl,
    input  logic [CW-1:0]               i_col,
    input  logic [RW-1:0]               i_row,
    input  logic [msq_pkg::SIZE_W-1:0]  i_up,
    output logic [msq_pkg::SIZE_W-1:0]  o_size,
    output msq_pkg::t_beat_ctl          o_ctl,
    output logic [msq_pkg::SIZE_W-1:0]  o_s2_size,
    output logic [CW-1:0]               o_s2_col,
    output logic [RW-1:0]               o_s2_row
);
    import msq_pkg::*;

    logic [SIZE_W-1:0] r_left, n_left;
    logic [SIZE_W-1:0] r_diag, n_diag;
    logic [SIZE_W-1:0] min_lu;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] size;
    t_beat_ctl         r_s2_ctl;
    logic [SIZE_W-1:0] r_s2_size;
    logic [CW-1:0]     r_s2_col;
    logic [RW-1:0]     r_s2_row;

    always_comb begin
        min_lu  = (r_left < i_up) ? r_left : i_up;
        min_all = (min_lu < r_diag) ? min_lu : r_diag;
        priority if (!i_ctl.is_set) begin
            size = '0;
        end else if (i_ctl.first) begin
            size = SIZE_W'(1);
        end else if (min_all == SIZE_LIMIT) begin
            size = SIZE_LIMIT;
        end else begin
            size = min_all + SIZE_W'(1);
        end
    end

    always_comb begin
        n_left = r_left;
        n_diag = r_diag;
        if (i_ctl.vld && i_adv) begin
            if (i_ctl.wrap || i_ctl.eof) begin
                n_left = '0;
                n_diag = '0;
            end else begin
                n_left = size;
                n_diag = i_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_diag   <= '0;
            r_s2_ctl <= '0;
        end else begin
            r_left <= n_left;
            r_diag <= n_diag;
            if (i_adv) begin
                r_s2_ctl <= i_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_size <= size;
            r_s2_col  <= i_col;
            r_s2_row  <= i_row;
        end
    end

    assign o_size    = size;
    assign o_ctl     = r_s2_ctl;
    assign o_s2_size = r_s2_size;
    assign o_s2_col  = r_s2_col;
    assign o_s2_row  = r_s2_row;

endmodule

// File: src/msq_best.sv
// Tracks the largest size and its first position; emits the result at frame end.
// Output register toward the result channel. Uses msq_pkg.
module msq_best #(
    parameter int CW = 10,
    parameter int RW = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  msq_pkg::t_beat_ctl              i_ctl,
    input  logic [msq_pkg::SIZE_W-1:0]      i_size,
    input  logic [CW-1:0]                   i_col,
    input  logic [RW-1:0]                   i_row,
    input  logic                            i_out_ready,
    output logic                            o_hold,
    output logic                            o_out_valid,
    output logic [msq_pkg::SIZE_W-1:0]      o_max_size,
    output logic [msq_pkg::POS_OUT_W-1:0]   o_top_row,
    output logic [msq_pkg::POS_OUT_W-1:0]   o_left_col
);
    import msq_pkg::*;

    localparam int PW = (RW > CW) ? RW : CW;
    localparam int XW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

    logic [SIZE_W-1:0]    r_best_size;
    logic [RW-1:0]        r_best_row;
    logic [CW-1:0]        r_best_col;
    logic                 r_out_valid;
    logic [SIZE_W-1:0]    r_max_size;
    logic [POS_OUT_W-1:0] r_top_row;
    logic [POS_OUT_W-1:0] r_left_col;
    logic                 take;
    logic                 beat;
    logic [SIZE_W-1:0]    fin_size;
    logic [RW-1:0]        fin_row;
    logic [CW-1:0]        fin_col;
    logic [XW-1:0]        top_full;
    logic [XW-1:0]        left_full;

    assign o_hold = i_ctl.vld && i_ctl.eof && r_out_valid && !i_out_ready;
    assign beat   = i_ctl.vld && !o_hold;
    assign take   = i_size > r_best_size;

    always_comb begin
        fin_size  = take ? i_size : r_best_size;
        fin_row   = take ? i_row  : r_best_row;
        fin_col   = take ? i_col  : r_best_col;
        // bottom-right corner back to top-left
        top_full  = XW'(fin_row) + XW'(1) - XW'(fin_size);
        left_full = XW'(fin_col) + XW'(1) - XW'(fin_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (beat) begin
                if (i_ctl.eof) begin
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                    r_out_valid <= 1'b1;
                end else if (take) begin
                    r_best_size <= i_size;
                    r_best_row  <= i_row;
                    r_best_col  <= i_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat && i_ctl.eof) begin
            r_max_size <= fin_size;
            if (fin_size == '0) begin
                r_top_row  <= '0;
                r_left_col <= '0;
            end else begin
                r_top_row  <= top_full[POS_OUT_W-1:0];
                r_left_col <= left_full[POS_OUT_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_size  = r_max_size;
    assign o_top_row   = r_top_row;
    assign o_left_col  = r_left_col;

endmodule

// File: tb/tb_top.sv
// Self-checking bench for max_square_of_ones: a table of directed frames, a full-output
// backpressure phase, then random frames, checked against fixed answers or an in-bench DP tracker.
// Depends on msq_pkg and the max_square_of_ones RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msq_pkg::*;

    localparam int NCOLS_MAX    = DEF_MAX_COLS;
    localparam int NROWS_MAX    = DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 28;
    localparam int RAND_CELLS   = 500;

    typedef struct packed {
        logic [SIZE_W-1:0]    size;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
    } t_square;

    typedef enum logic [2:0] {
        PAT_ZERO,
        PAT_ONES,
        PAT_STRIPE,
        PAT_LAST,
        PAT_RAND
    } t_pattern;

    typedef struct packed {
        logic             wr_cols;
        logic [CFG_W-1:0] cols;
        int               cells;
        t_pattern         pat;
        logic             fixed;
        t_square          want;
    } t_frame_case;

    localparam int NUM_DIR = 17;

    // Rows with fixed set carry the answer; the rest go through the tracker.
    localparam t_frame_case DIR_FRAMES [NUM_DIR] = '{
        '{1'b0, 11'd0,       3, PAT_LAST,   1'b1, '{11'd1, 10'd0,    10'd2}},  // reset width
        '{1'b1, 11'd1,       3, PAT_ZERO,   1'b1, '{11'd0, 10'd0,    10'd0}},  // no set cell
        '{1'b0, 11'd1,       5, PAT_ONES,   1'b1, '{11'd1, 10'd0,    10'd0}},
        '{1'b1, 11'd4,      16, PAT_ONES,   1'b1, '{11'd4, 10'd0,    10'd0}},
        '{1'b1, 11'd3,      15, PAT_ONES,   1'b1, '{11'd3, 10'd0,    10'd0}},
        '{1'b1, 11'd8,      32, PAT_STRIPE, 1'b1, '{11'd2, 10'd0,    10'd0}},  // ties
        '{1'b1, 11'd5,      15, PAT_LAST,   1'b1, '{11'd1, 10'd2,    10'd4}},
        '{1'b1, 11'd0,       4, PAT_LAST,   1'b1, '{11'd1, 10'd3,    10'd0}},  // 0 acts as 1
        '{1'b1, 11'd2047,    5, PAT_LAST,   1'b1, '{11'd1, 10'd0,    10'd4}},  // clamps
        '{1'b1, 11'd1500,    7, PAT_LAST,   1'b1, '{11'd1, 10'd0,    10'd6}},
        '{1'b1, 11'd1,       6, PAT_LAST,   1'b1, '{11'd1, 10'd5,    10'd0}},
        '{1'b1, 11'd4,       6, PAT_ONES,   1'b1, '{11'd2, 10'd0,    10'd0}},  // mid-row end
        '{1'b0, 11'd4,       4, PAT_ONES,   1'b1, '{11'd1, 10'd0,    10'd0}},
        '{1'b1, 11'd3,       1, PAT_ONES,   1'b1, '{11'd1, 10'd0,    10'd0}},
        '{1'b1, 11'd6,      20, PAT_RAND,   1'b0, '{11'd0, 10'd0,    10'd0}},
        '{1'b1, 11'd7,      30, PAT_RAND,   1'b0, '{11'd0, 10'd0,    10'd0}},
        '{1'b1, 11'd16,    200, PAT_RAND,   1'b0, '{11'd0, 10'd0,    10'd0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_cell_req;
    logic                 i_end_of_frame;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SIZE_W-1:0]    o_max_size;
    logic [POS_OUT_W-1:0] o_top_row;
    logic [POS_OUT_W-1:0] o_left_col;

    // Tracker state
    logic [CFG_W-1:0]     cols_reg;
    logic [SIZE_W-1:0]    row_sizes [NCOLS_MAX];
    logic [SIZE_W-1:0]    left_sz;
    logic [SIZE_W-1:0]    diag_sz;
    logic [SIZE_W-1:0]    best_sz;
    logic [POS_OUT_W-1:0] col_pos;
    logic [POS_OUT_W-1:0] row_pos;
    logic [POS_OUT_W-1:0] best_r;
    logic [POS_OUT_W-1:0] best_c;

    t_square expected_squares [$];
    int      errors      = 0;
    int      cycle_count = 0;
    bit      burst_mode  = 1'b0;
    bit      hold_req    = 1'b0;
    int      hold_left   = 0;

    always #1 i_clk = ~i_clk;

    max_square_of_ones u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cell_req     (i_cell_req),
        .i_end_of_frame (i_end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_max_size     (o_max_size),
        .o_top_row      (o_top_row),
        .o_left_col     (o_left_col)
    );

    function automatic int cols_active();
        if (cols_reg == 0)
            return 1;
        if (int'(cols_reg) > NCOLS_MAX)
            return NCOLS_MAX;
        return int'(cols_reg);
    endfunction

    function automatic void clear_frame();
        left_sz = '0;
        diag_sz = '0;
        col_pos = '0;
        row_pos = '0;
        best_sz = '0;
        best_r  = '0;
        best_c  = '0;
    endfunction

    // One raster cell through the DP; returns 1 with the square on a frame end.
    function automatic bit track_cell(input logic cell_val, input logic eof,
                                      output t_square sq);
        logic [SIZE_W-1:0] up;
        logic [SIZE_W-1:0] sz;
        logic [SIZE_W-1:0] m;
        up = row_sizes[col_pos];
        if (!cell_val) begin
            sz = '0;
        end else if (row_pos == 0 || col_pos == 0) begin
            sz = SIZE_W'(1);
        end else begin
            m = (left_sz < up) ? left_sz : up;
            if (diag_sz < m)
                m = diag_sz;
            sz = (m >= SIZE_LIMIT) ? SIZE_LIMIT : m + 1'b1;
        end
        diag_sz = up;
        left_sz = sz;
        row_sizes[col_pos] = sz;
        if (sz > best_sz) begin
            best_sz = sz;
            best_r  = row_pos;
            best_c  = col_pos;
        end
        if (int'(col_pos) + 1 >= cols_active()) begin
            col_pos = '0;
            left_sz = '0;
            diag_sz = '0;
            if (int'(row_pos) + 1 < NROWS_MAX)
                row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        sq = '0;
        if (!eof)
            return 1'b0;
        if (best_sz != 0) begin
            sq.size = best_sz;
            // bottom-right to top-left, modulo the 10-bit position width
            sq.row  = best_r + 1'b1 - best_sz[POS_OUT_W-1:0];
            sq.col  = best_c + 1'b1 - best_sz[POS_OUT_W-1:0];
        end
        clear_frame();
        return 1'b1;
    endfunction

    task automatic send_cell(input logic cell_val, input logic eof, input logic fixed,
                             input t_square fixed_sq);
        t_square sq;
        if (!burst_mode) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_cell_req     <= cell_val;
        i_end_of_frame <= eof;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (track_cell(cell_val, eof, sq))
            expected_squares.push_back(fixed ? fixed_sq : sq);
    endtask

    // Drop valid, let every result come back and the pipe go quiet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_squares.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_cols(input logic [CFG_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        cols_reg = value;
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check the beat, then pick next cycle's ready.
    initial begin
        t_square want_sq;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_squares.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, %s %0d row %0d col %0d",
                             $time, "actual size", o_max_size, o_top_row, o_left_col);
                end else begin
                    want_sq = expected_squares.pop_front();
                    if (o_max_size !== want_sq.size) begin
                        errors++;
                        $display("%0t: max_size mismatch: expected %0d, actual %0d",
                                 $time, want_sq.size, o_max_size);
                    end
                    if (o_top_row !== want_sq.row) begin
                        errors++;
                        $display("%0t: top_row mismatch: expected %0d, actual %0d",
                                 $time, want_sq.row, o_top_row);
                    end
                    if (o_left_col !== want_sq.col) begin
                        errors++;
                        $display("%0t: left_col mismatch: expected %0d, actual %0d",
                                 $time, want_sq.col, o_left_col);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        t_frame_case fc;
        int          eff;
        int          cells;
        int          dens;
        int          pick;
        int          grp;
        int          rand_cells;
        logic        c;

        i_rst_n        = 1'b0;
        i_cfg_wen      = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_cell_req     = 1'b0;
        i_end_of_frame = 1'b0;
        i_out_ready    = 1'b0;
        cols_reg       = NUM_COLS_RST;
        for (int i = 0; i < NCOLS_MAX; i++)
            row_sizes[i] = '0;
        clear_frame();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames; the last one runs with no idling on either side
        for (int f = 0; f < NUM_DIR; f++) begin
            fc = DIR_FRAMES[f];
            if (fc.wr_cols) begin
                wait_idle();
                set_cols(fc.cols);
            end
            burst_mode = (f == NUM_DIR - 1);
            eff = cols_active();
            for (int k = 0; k < fc.cells; k++) begin
                case (fc.pat)
                    PAT_ZERO:   c = 1'b0;
                    PAT_ONES:   c = 1'b1;
                    PAT_STRIPE: c = ((k % eff) % 3) != 2;
                    PAT_LAST:   c = (k == fc.cells - 1);
                    default:    c = 1'($urandom_range(0, 1));
                endcase
                send_cell(c, k == fc.cells - 1, fc.fixed, fc.want);
            end
        end
        burst_mode = 1'b0;

        // result side holds off while short frames keep coming; input must stall
        wait_idle();
        set_cols(11'd2);
        hold_req = 1'b1;
        for (int f = 0; f < 30; f++)
            for (int k = 0; k < 4; k++)
                send_cell(1'($urandom_range(0, 1)), k == 3, 1'b0, '0);

        // random frames, mostly narrow; some end mid-row
        rand_cells = 0;
        grp        = 0;
        while (rand_cells < RAND_CELLS) begin
            pick = $urandom_range(0, 99);
            wait_idle();
            if (pick < 70)
                set_cols(CFG_W'($urandom_range(1, 8)));
            else if (pick < 92)
                set_cols(CFG_W'($urandom_range(9, 40)));
            else
                set_cols('0);
            burst_mode = (grp >= 1 && grp < 3);
            eff = cols_active();
            repeat ($urandom_range(2, 6)) begin
                cells = $urandom_range(1, 8) * eff;
                if ($urandom_range(0, 3) == 0)
                    cells = $urandom_range(1, cells + eff);
                case ($urandom_range(0, 3))
                    0:       dens = 50;
                    1:       dens = 80;
                    2:       dens = 95;
                    default: dens = 100;
                endcase
                for (int k = 0; k < cells; k++) begin
                    send_cell($urandom_range(0, 99) < dens, k == cells - 1, 1'b0, '0);
                    rand_cells++;
                end
            end
            grp++;
        end
        burst_mode = 1'b0;

        wait_idle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
